### hdl/i2car_pkg.sv
// Shared types, register addresses and constant tables of the I2C authentication register file.
package i2car_pkg;

    typedef enum logic [1:0] {
        FUNC_WRITE_START = 2'd0,
        FUNC_WRITE_BYTE  = 2'd1,
        FUNC_READ_BYTE   = 2'd2,
        FUNC_OTHER       = 2'd3
    } func_t;

    // Configuration port.
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 48;
    localparam logic [CFG_ADDR_W-1:0] CFG_DEVICE_ID     = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_MAJOR_VERSION = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_ID_SERIAL     = 2'd2;

    localparam logic [31:0] DEVICE_ID_RESET     = 32'hDEADBEEF;
    localparam logic [7:0]  MAJOR_VERSION_RESET = 8'h02;
    localparam logic [47:0] ID_SERIAL_RESET     = 48'd73990784643959;

    // Register addresses.
    localparam logic [7:0] REG_VERSION_LAST = 8'h04;
    localparam logic [7:0] REG_ERROR        = 8'h05;
    localparam logic [7:0] REG_STATUS       = 8'h10;
    localparam logic [7:0] REG_SIG_LEN      = 8'h11;
    localparam logic [7:0] REG_SIGNATURE    = 8'h12;
    localparam logic [7:0] REG_CHAL_LEN     = 8'h20;
    localparam logic [7:0] REG_CHALLENGE    = 8'h21;
    localparam logic [7:0] REG_CERT_LEN     = 8'h30;
    localparam logic [7:0] REG_CERT_FIRST   = 8'h31;
    localparam logic [7:0] REG_CERT_LAST    = 8'h3A;
    localparam logic [7:0] REG_PROTO        = 8'h40;
    localparam logic [7:0] REG_SERIAL_ROM   = 8'h4E;
    localparam logic [7:0] REG_ID_SERIAL    = 8'h60;

    localparam logic [7:0] PROTO_BYTE      = 8'h50;
    localparam logic [7:0] STATUS_SIG_DONE = 8'h10;

    localparam int SERIAL_ROM_LEN = 32;
    localparam int CERT_ROM_LEN   = 609;
    localparam int CERT_ROM_AW    = $clog2(CERT_ROM_LEN);

    // One finished item between the register file and the output stage.
    typedef struct packed {
        logic [7:0]             data;
        logic                   past_end;
        logic                   cert_sel;
        logic [CERT_ROM_AW-1:0] cert_idx;
    } stage_item_t;

    localparam logic [7:0] SERIAL_ROM [SERIAL_ROM_LEN] = '{
        8'hAA, 8'h56, 8'hCB, 8'h46, 8'h35, 8'h01, 8'h55, 8'hED, 8'h3A, 8'h08, 8'h7A, 8'h58,
        8'h1C, 8'h17, 8'hBA, 8'hCB, 8'h94, 8'hD0, 8'h9C, 8'h71, 8'h9B, 8'h97, 8'h3F, 8'h67,
        8'hF0, 8'hFC, 8'h2D, 8'h6B, 8'h13, 8'h8D, 8'h3E, 8'h90
    };

    localparam logic [7:0] CERT_ROM [CERT_ROM_LEN] = '{
        8'h30, 8'h82, 8'h02, 8'h5D, 8'h30, 8'h82, 8'h02, 8'h03, 8'hA0, 8'h03, 8'h02, 8'h01,
        8'h02, 8'h02, 8'h14, 8'h6A, 8'h19, 8'h09, 8'h84, 8'h79, 8'hF4, 8'h89, 8'hBC, 8'h0F,
        8'h5E, 8'hEB, 8'h82, 8'h51, 8'h0C, 8'hE8, 8'hDC, 8'h4F, 8'h24, 8'h82, 8'hD8, 8'h30,
        8'h0A, 8'h06, 8'h08, 8'h2A, 8'h86, 8'h48, 8'hCE, 8'h3D, 8'h04, 8'h03, 8'h02, 8'h30,
        8'h81, 8'h9C, 8'h31, 8'h18, 8'h30, 8'h16, 8'h06, 8'h03, 8'h55, 8'h04, 8'h03, 8'h0C,
        8'h0F, 8'h49, 8'h6E, 8'h66, 8'h65, 8'h72, 8'h6E, 8'h6F, 8'h20, 8'h52, 8'h6F, 8'h73,
        8'h77, 8'h65, 8'h6C, 8'h6C, 8'h31, 8'h45, 8'h30, 8'h43, 8'h06, 8'h03, 8'h55, 8'h04,
        8'h0B, 8'h0C, 8'h3C, 8'h45, 8'h6D, 8'h75, 8'h6C, 8'h61, 8'h74, 8'h65, 8'h64, 8'h20,
        8'h41, 8'h70, 8'h70, 8'h6C, 8'h65, 8'h20, 8'h41, 8'h75, 8'h74, 8'h68, 8'h65, 8'h6E,
        8'h74, 8'h69, 8'h63, 8'h61, 8'h74, 8'h69, 8'h6F, 8'h6E, 8'h20, 8'h43, 8'h6F, 8'h70,
        8'h72, 8'h6F, 8'h63, 8'h65, 8'h73, 8'h73, 8'h6F, 8'h72, 8'h20, 8'h2D, 8'h20, 8'h49,
        8'h6E, 8'h66, 8'h65, 8'h72, 8'h6E, 8'h6F, 8'h20, 8'h65, 8'h6D, 8'h75, 8'h6C, 8'h61,
        8'h74, 8'h6F, 8'h72, 8'h31, 8'h39, 8'h30, 8'h37, 8'h06, 8'h03, 8'h55, 8'h04, 8'h0B,
        8'h0C, 8'h30, 8'h70, 8'h6C, 8'h61, 8'h63, 8'h65, 8'h68, 8'h6F, 8'h6C, 8'h64, 8'h65,
        8'h72, 8'h20, 8'h2E, 8'h2E, 8'h2E, 8'h2E, 8'h2E, 8'h2E, 8'h2E, 8'h2E, 8'h2E, 8'h2E,
        8'h2E, 8'h2E, 8'h2E, 8'h2E, 8'h2E, 8'h2E, 8'h2E, 8'h2E, 8'h2E, 8'h2E, 8'h2E, 8'h2E,
        8'h2E, 8'h2E, 8'h2E, 8'h2E, 8'h2E, 8'h2E, 8'h2E, 8'h2E, 8'h2E, 8'h2E, 8'h2E, 8'h2E,
        8'h2E, 8'h2E, 8'h30, 8'h1E, 8'h17, 8'h0D, 8'h32, 8'h36, 8'h30, 8'h37, 8'h33, 8'h31,
        8'h31, 8'h34, 8'h30, 8'h30, 8'h34, 8'h34, 8'h5A, 8'h17, 8'h0D, 8'h34, 8'h36, 8'h30,
        8'h37, 8'h32, 8'h36, 8'h31, 8'h34, 8'h30, 8'h30, 8'h34, 8'h34, 8'h5A, 8'h30, 8'h81,
        8'h9C, 8'h31, 8'h18, 8'h30, 8'h16, 8'h06, 8'h03, 8'h55, 8'h04, 8'h03, 8'h0C, 8'h0F,
        8'h49, 8'h6E, 8'h66, 8'h65, 8'h72, 8'h6E, 8'h6F, 8'h20, 8'h52, 8'h6F, 8'h73, 8'h77,
        8'h65, 8'h6C, 8'h6C, 8'h31, 8'h45, 8'h30, 8'h43, 8'h06, 8'h03, 8'h55, 8'h04, 8'h0B,
        8'h0C, 8'h3C, 8'h45, 8'h6D, 8'h75, 8'h6C, 8'h61, 8'h74, 8'h65, 8'h64, 8'h20, 8'h41,
        8'h70, 8'h70, 8'h6C, 8'h65, 8'h20, 8'h41, 8'h75, 8'h74, 8'h68, 8'h65, 8'h6E, 8'h74,
        8'h69, 8'h63, 8'h61, 8'h74, 8'h69, 8'h6F, 8'h6E, 8'h20, 8'h43, 8'h6F, 8'h70, 8'h72,
        8'h6F, 8'h63, 8'h65, 8'h73, 8'h73, 8'h6F, 8'h72, 8'h20, 8'h2D, 8'h20, 8'h49, 8'h6E,
        8'h66, 8'h65, 8'h72, 8'h6E, 8'h6F, 8'h20, 8'h65, 8'h6D, 8'h75, 8'h6C, 8'h61, 8'h74,
        8'h6F, 8'h72, 8'h31, 8'h39, 8'h30, 8'h37, 8'h06, 8'h03, 8'h55, 8'h04, 8'h0B, 8'h0C,
        8'h30, 8'h70, 8'h6C, 8'h61, 8'h63, 8'h65, 8'h68, 8'h6F, 8'h6C, 8'h64, 8'h65, 8'h72,
        8'h20, 8'h2E, 8'h2E, 8'h2E, 8'h2E, 8'h2E, 8'h2E, 8'h2E, 8'h2E, 8'h2E, 8'h2E, 8'h2E,
        8'h2E, 8'h2E, 8'h2E, 8'h2E, 8'h2E, 8'h2E, 8'h2E, 8'h2E, 8'h2E, 8'h2E, 8'h2E, 8'h2E,
        8'h2E, 8'h2E, 8'h2E, 8'h2E, 8'h2E, 8'h2E, 8'h2E, 8'h2E, 8'h2E, 8'h2E, 8'h2E, 8'h2E,
        8'h2E, 8'h30, 8'h59, 8'h30, 8'h13, 8'h06, 8'h07, 8'h2A, 8'h86, 8'h48, 8'hCE, 8'h3D,
        8'h02, 8'h01, 8'h06, 8'h08, 8'h2A, 8'h86, 8'h48, 8'hCE, 8'h3D, 8'h03, 8'h01, 8'h07,
        8'h03, 8'h42, 8'h00, 8'h04, 8'h45, 8'h77, 8'h46, 8'h61, 8'hE3, 8'hB8, 8'h8B, 8'h98,
        8'hB8, 8'h6C, 8'hEF, 8'hFC, 8'h08, 8'hA7, 8'h5A, 8'h5E, 8'hA5, 8'h0F, 8'hDE, 8'h86,
        8'h85, 8'hAD, 8'hB7, 8'hB5, 8'hDF, 8'h9C, 8'h04, 8'hE6, 8'h0E, 8'h13, 8'h4E, 8'h9A,
        8'hAE, 8'h0F, 8'h18, 8'h1C, 8'h39, 8'h9E, 8'h0E, 8'hF4, 8'h83, 8'h13, 8'h6A, 8'hCE,
        8'h8E, 8'h75, 8'h35, 8'h4E, 8'hFC, 8'hA4, 8'hC2, 8'h48, 8'h33, 8'hCE, 8'hCA, 8'h7A,
        8'hE5, 8'h9F, 8'h30, 8'h2E, 8'h7B, 8'h82, 8'h17, 8'h03, 8'hA3, 8'h21, 8'h30, 8'h1F,
        8'h30, 8'h1D, 8'h06, 8'h03, 8'h55, 8'h1D, 8'h0E, 8'h04, 8'h16, 8'h04, 8'h14, 8'h9B,
        8'hE8, 8'hD1, 8'h53, 8'h8A, 8'hC0, 8'hB9, 8'h69, 8'hEB, 8'h03, 8'h75, 8'h3A, 8'hC7,
        8'hC0, 8'hE1, 8'h01, 8'hC5, 8'h0D, 8'h89, 8'hDA, 8'h30, 8'h0A, 8'h06, 8'h08, 8'h2A,
        8'h86, 8'h48, 8'hCE, 8'h3D, 8'h04, 8'h03, 8'h02, 8'h03, 8'h48, 8'h00, 8'h30, 8'h45,
        8'h02, 8'h20, 8'h33, 8'h60, 8'h3C, 8'h32, 8'h88, 8'h98, 8'h7E, 8'h71, 8'hA6, 8'h5D,
        8'h78, 8'h9F, 8'hB9, 8'hB4, 8'h7C, 8'h37, 8'h41, 8'h4C, 8'h3B, 8'hD9, 8'h2B, 8'h49,
        8'hD6, 8'hAF, 8'h97, 8'h02, 8'hE3, 8'h26, 8'h60, 8'hF3, 8'h5F, 8'hCD, 8'h02, 8'h21,
        8'h00, 8'hD0, 8'h92, 8'hBF, 8'h4F, 8'h20, 8'hCB, 8'hA7, 8'h6B, 8'hF0, 8'h1D, 8'h66,
        8'hCE, 8'h41, 8'hF0, 8'h1B, 8'hC7, 8'h92, 8'hCF, 8'hF5, 8'hAD, 8'h98, 8'h23, 8'hC5,
        8'h9D, 8'hC0, 8'h09, 8'hA7, 8'hBE, 8'hEB, 8'h91, 8'hA9, 8'h6E
    };

endpackage

### hdl/i2car_regfile.sv
// Register file state, bus byte decoding and the first result register stage.
module i2car_regfile #(
    parameter int CERT_BYTES      = 609,
    parameter int PAGE_BYTES      = 128,
    parameter int CHALLENGE_BYTES = 32,
    parameter int SIGNATURE_BYTES = 64
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [i2car_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [i2car_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [1:0]                          s_func,
    input  logic [7:0]                          s_data,
    output logic                                a_valid,
    input  logic                                a_ready,
    output i2car_pkg::stage_item_t              a_item
);

    localparam int LEN_A   = (CERT_BYTES > SIGNATURE_BYTES) ? CERT_BYTES : SIGNATURE_BYTES;
    localparam int LEN_B   = (CHALLENGE_BYTES > 32) ? CHALLENGE_BYTES : 32;
    localparam int LEN_MAX = (LEN_A > LEN_B) ? LEN_A : LEN_B;
    localparam int POS_W   = $clog2(LEN_MAX + 1);
    localparam int IDX_W   = $clog2(9 * PAGE_BYTES + LEN_MAX + 1);
    localparam int CIDX_W  = (CHALLENGE_BYTES > 1) ? $clog2(CHALLENGE_BYTES) : 1;

    localparam logic [IDX_W-1:0]  PAGE_W       = IDX_W'(PAGE_BYTES);
    localparam logic [IDX_W-1:0]  CERT_W       = IDX_W'(CERT_BYTES);
    localparam logic [IDX_W-1:0]  CERT_ROM_W   = IDX_W'(i2car_pkg::CERT_ROM_LEN);
    localparam logic [15:0]       SIG_LEN16    = 16'(SIGNATURE_BYTES);
    localparam logic [15:0]       CERT_LEN16   = 16'(CERT_BYTES);
    localparam logic [CIDX_W-1:0] CIDX_LAST    = CIDX_W'(CHALLENGE_BYTES - 1);
    localparam logic [5:0]        WPOS_MAX     = 6'd63;
    localparam logic [6:0]        CHAL_BYTES_W = 7'(CHALLENGE_BYTES);

    logic [31:0] device_id_reg;
    logic [7:0]  major_reg;
    logic [47:0] id_serial_reg;

    logic [7:0]        sel_reg, sel_next;
    logic              addr_phase_reg, addr_phase_next;
    logic [7:0]        err_reg, err_next;
    logic [7:0]        ctrl_reg, ctrl_next;
    logic [15:0]       clen_reg, clen_next;
    logic [5:0]        wpos_reg, wpos_next;
    logic [POS_W-1:0]  rpos_reg, rpos_next;
    logic [POS_W-1:0]  rlen_reg, rlen_next;
    logic [CIDX_W-1:0] cidx_reg, cidx_next;
    logic [15:0]       snap_reg, snap_next;
    logic [7:0]        store_reg [CHALLENGE_BYTES];
    logic [7:0]        store_next [CHALLENGE_BYTES];
    logic [7:0]        csnap_reg [CHALLENGE_BYTES];
    logic [7:0]        csnap_next [CHALLENGE_BYTES];

    logic                   a_valid_reg;
    i2car_pkg::stage_item_t a_item_reg, a_item_next;

    logic             accept;
    logic [7:0]       reply;
    logic [3:0]       ver_k;
    logic [IDX_W-1:0] cert_idx;
    logic [IDX_W-1:0] sel_off;
    logic [7:0]       page_new;
    logic [IDX_W-1:0] new_off;

    assign s_ready = !a_valid_reg || a_ready;
    assign accept  = s_valid && s_ready;
    assign a_valid = a_valid_reg;
    assign a_item  = a_item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            device_id_reg <= i2car_pkg::DEVICE_ID_RESET;
            major_reg     <= i2car_pkg::MAJOR_VERSION_RESET;
            id_serial_reg <= i2car_pkg::ID_SERIAL_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                i2car_pkg::CFG_DEVICE_ID:     device_id_reg <= cfg_wdata[31:0];
                i2car_pkg::CFG_MAJOR_VERSION: major_reg     <= cfg_wdata[7:0];
                i2car_pkg::CFG_ID_SERIAL:     id_serial_reg <= cfg_wdata[47:0];
                default: ;
            endcase
        end
    end

    // Certificate offsets of the current register and of a byte that selects one.
    assign sel_off  = IDX_W'(sel_reg - i2car_pkg::REG_CERT_FIRST) * PAGE_W;
    assign cert_idx = sel_off + IDX_W'(rpos_reg);
    assign page_new = s_data - i2car_pkg::REG_CERT_FIRST;
    assign new_off  = IDX_W'(page_new[3:0]) * PAGE_W;
    assign ver_k    = {1'b0, rpos_reg[2:0]} + {1'b0, sel_reg[2:0]};

    // Byte at the current read position of the selected register.
    always_comb begin
        reply = 8'h00;
        if (sel_reg inside {[i2car_pkg::REG_CERT_FIRST:i2car_pkg::REG_CERT_LAST]}) begin
            reply = 8'h00;
        end else if (sel_reg <= i2car_pkg::REG_VERSION_LAST) begin
            case (ver_k)
                4'd2:    reply = major_reg;
                4'd4:    reply = device_id_reg[31:24];
                4'd5:    reply = device_id_reg[23:16];
                4'd6:    reply = device_id_reg[15:8];
                4'd7:    reply = device_id_reg[7:0];
                default: reply = 8'h00;
            endcase
        end else begin
            case (sel_reg)
                i2car_pkg::REG_ERROR,
                i2car_pkg::REG_STATUS:    reply = snap_reg[7:0];
                i2car_pkg::REG_SIG_LEN:
                    reply = (rpos_reg == '0) ? SIG_LEN16[15:8] : SIG_LEN16[7:0];
                i2car_pkg::REG_SIGNATURE: reply = csnap_reg[cidx_reg] ^ rpos_reg[7:0];
                i2car_pkg::REG_CHAL_LEN:
                    reply = (rpos_reg == '0) ? snap_reg[15:8] : snap_reg[7:0];
                i2car_pkg::REG_CHALLENGE: reply = csnap_reg[cidx_reg];
                i2car_pkg::REG_CERT_LEN:
                    reply = (rpos_reg == '0) ? CERT_LEN16[15:8] : CERT_LEN16[7:0];
                i2car_pkg::REG_PROTO:     reply = i2car_pkg::PROTO_BYTE;
                i2car_pkg::REG_SERIAL_ROM: reply = i2car_pkg::SERIAL_ROM[rpos_reg[4:0]];
                i2car_pkg::REG_ID_SERIAL: begin
                    case (rpos_reg[2:0])
                        3'd1:    reply = id_serial_reg[47:40];
                        3'd2:    reply = id_serial_reg[39:32];
                        3'd3:    reply = id_serial_reg[31:24];
                        3'd4:    reply = id_serial_reg[23:16];
                        3'd5:    reply = id_serial_reg[15:8];
                        3'd6:    reply = id_serial_reg[7:0];
                        default: reply = 8'h00;
                    endcase
                end
                default: reply = 8'h00;
            endcase
        end
    end

    always_comb begin
        sel_next        = sel_reg;
        addr_phase_next = addr_phase_reg;
        err_next        = err_reg;
        ctrl_next       = ctrl_reg;
        clen_next       = clen_reg;
        wpos_next       = wpos_reg;
        rpos_next       = rpos_reg;
        rlen_next       = rlen_reg;
        cidx_next       = cidx_reg;
        snap_next       = snap_reg;
        for (int i = 0; i < CHALLENGE_BYTES; i++) begin
            store_next[i] = store_reg[i];
            csnap_next[i] = csnap_reg[i];
        end
        a_item_next          = '0;
        a_item_next.cert_idx = cert_idx[i2car_pkg::CERT_ROM_AW-1:0];

        case (i2car_pkg::func_t'(s_func))
            i2car_pkg::FUNC_WRITE_START: begin
                addr_phase_next = 1'b1;
                wpos_next       = '0;
            end
            i2car_pkg::FUNC_WRITE_BYTE: begin
                if (addr_phase_reg) begin
                    // Register selection: rewind and take the snapshots.
                    sel_next        = s_data;
                    addr_phase_next = 1'b0;
                    wpos_next       = '0;
                    rpos_next       = '0;
                    cidx_next       = '0;
                    snap_next       = '0;
                    for (int i = 0; i < CHALLENGE_BYTES; i++) begin
                        csnap_next[i] = store_reg[i];
                    end
                    rlen_next = '0;
                    if (s_data inside
                        {[i2car_pkg::REG_CERT_FIRST:i2car_pkg::REG_CERT_LAST]}) begin
                        if (new_off < CERT_W) begin
                            rlen_next = POS_W'(CERT_W - new_off);
                        end
                    end else if (s_data <= i2car_pkg::REG_VERSION_LAST) begin
                        rlen_next = POS_W'(4'd8 - {1'b0, s_data[2:0]});
                    end else begin
                        case (s_data)
                            i2car_pkg::REG_ERROR: begin
                                snap_next = {8'h00, err_reg};
                                rlen_next = POS_W'(1);
                            end
                            i2car_pkg::REG_STATUS: begin
                                snap_next = {8'h00, ctrl_reg};
                                rlen_next = POS_W'(1);
                            end
                            i2car_pkg::REG_SIG_LEN:    rlen_next = POS_W'(2);
                            i2car_pkg::REG_SIGNATURE:  rlen_next = POS_W'(SIGNATURE_BYTES);
                            i2car_pkg::REG_CHAL_LEN: begin
                                // The length is cleared before it is captured.
                                clen_next = '0;
                                rlen_next = POS_W'(2);
                            end
                            i2car_pkg::REG_CHALLENGE:  rlen_next = POS_W'(CHALLENGE_BYTES);
                            i2car_pkg::REG_CERT_LEN:   rlen_next = POS_W'(2);
                            i2car_pkg::REG_PROTO:      rlen_next = POS_W'(1);
                            i2car_pkg::REG_SERIAL_ROM:
                                rlen_next = POS_W'(i2car_pkg::SERIAL_ROM_LEN);
                            i2car_pkg::REG_ID_SERIAL:  rlen_next = POS_W'(7);
                            default:                   rlen_next = '0;
                        endcase
                    end
                end else begin
                    case (sel_reg)
                        i2car_pkg::REG_ERROR: err_next = s_data;
                        i2car_pkg::REG_STATUS: begin
                            ctrl_next = s_data;
                            if (s_data[0]) begin
                                ctrl_next = i2car_pkg::STATUS_SIG_DONE;
                                err_next  = 8'h00;
                            end
                        end
                        i2car_pkg::REG_CHAL_LEN: begin
                            if (wpos_reg < 6'd2) begin
                                clen_next = {clen_reg[7:0], s_data};
                            end
                        end
                        i2car_pkg::REG_CHALLENGE: begin
                            if ({1'b0, wpos_reg} < CHAL_BYTES_W) begin
                                store_next[wpos_reg[CIDX_W-1:0]] = s_data;
                            end
                        end
                        default: ;
                    endcase
                    if (wpos_reg != WPOS_MAX) begin
                        wpos_next = wpos_reg + 6'd1;
                    end
                end
            end
            i2car_pkg::FUNC_READ_BYTE: begin
                if (rpos_reg >= rlen_reg) begin
                    a_item_next.past_end = 1'b1;
                end else begin
                    if (sel_reg inside
                        {[i2car_pkg::REG_CERT_FIRST:i2car_pkg::REG_CERT_LAST]}) begin
                        // Bytes beyond the built-in certificate read as zero.
                        a_item_next.cert_sel = (cert_idx < CERT_ROM_W);
                    end else begin
                        a_item_next.data = reply;
                    end
                    rpos_next = rpos_reg + POS_W'(1);
                    cidx_next = (cidx_reg == CIDX_LAST) ? '0 : cidx_reg + CIDX_W'(1);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sel_reg        <= '0;
            addr_phase_reg <= 1'b1;
            err_reg        <= '0;
            ctrl_reg       <= '0;
            clen_reg       <= '0;
            wpos_reg       <= '0;
            rpos_reg       <= '0;
            rlen_reg       <= '0;
            cidx_reg       <= '0;
            snap_reg       <= '0;
            a_valid_reg    <= 1'b0;
            for (int i = 0; i < CHALLENGE_BYTES; i++) begin
                store_reg[i] <= '0;
                csnap_reg[i] <= '0;
            end
        end else begin
            if (accept) begin
                sel_reg        <= sel_next;
                addr_phase_reg <= addr_phase_next;
                err_reg        <= err_next;
                ctrl_reg       <= ctrl_next;
                clen_reg       <= clen_next;
                wpos_reg       <= wpos_next;
                rpos_reg       <= rpos_next;
                rlen_reg       <= rlen_next;
                cidx_reg       <= cidx_next;
                snap_reg       <= snap_next;
                for (int i = 0; i < CHALLENGE_BYTES; i++) begin
                    store_reg[i] <= store_next[i];
                    csnap_reg[i] <= csnap_next[i];
                end
                a_valid_reg <= 1'b1;
            end else if (a_ready) begin
                a_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            a_item_reg <= a_item_next;
        end
    end

endmodule

### hdl/i2car_out_stage.sv
// Output register stage with the registered certificate ROM read.
module i2car_out_stage (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   a_valid,
    output logic                   a_ready,
    input  i2car_pkg::stage_item_t a_item,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [7:0]             m_read_data,
    output logic                   m_past_end
);

    logic       m_valid_reg;
    logic [7:0] data_reg;
    logic       past_end_reg;

    assign a_ready     = !m_valid_reg || m_ready;
    assign m_valid     = m_valid_reg;
    assign m_read_data = data_reg;
    assign m_past_end  = past_end_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (a_valid && a_ready) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (a_valid && a_ready) begin
            data_reg     <= a_item.cert_sel ? i2car_pkg::CERT_ROM[a_item.cert_idx]
                                            : a_item.data;
            past_end_reg <= a_item.past_end;
        end
    end

endmodule

### hdl/i2c_auth_register_file_slave.sv
// Top level of the I2C authentication coprocessor register file target.
//
// The input channel (s_valid/s_ready, s_func, s_data) carries one bus byte event per
// transfer: start of a write, a written byte, a byte read, or another event. Every
// accepted transfer produces exactly one result transfer on the output channel
// (m_valid/m_ready, m_read_data, m_past_end); only reads return nonzero data.
// The first written byte after a write start selects a register and snapshots its
// reply; later bytes update error, control, challenge length or challenge.
// The register file state and the result are updated at the accepting edge, and the
// output stage then reads the certificate ROM into the output register, which drives
// m_valid and the result transfer. Throughput is one item per cycle while the
// receiver keeps m_ready high.
// When the receiver stalls, one further item is taken into the middle stage and
// s_ready then drops until the output register drains; nothing is lost.
// Synchronous active-low reset restores the configuration defaults and empties the
// reply, so reads before a selection report past end.
// Configuration writes (cfg_wr_en, cfg_addr, cfg_wdata) take effect at once and must be
// made by the user only while the block is idle; the block leaves that check to the user.
module i2c_auth_register_file_slave #(
    parameter int CERT_BYTES      = 609,
    parameter int PAGE_BYTES      = 128,
    parameter int CHALLENGE_BYTES = 32,
    parameter int SIGNATURE_BYTES = 64
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [i2car_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [i2car_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [1:0]                       s_func,
    input  logic [7:0]                       s_data,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [7:0]                       m_read_data,
    output logic                             m_past_end
);

    logic                   a_valid;
    logic                   a_ready;
    i2car_pkg::stage_item_t a_item;

    i2car_regfile #(
        .CERT_BYTES      (CERT_BYTES),
        .PAGE_BYTES      (PAGE_BYTES),
        .CHALLENGE_BYTES (CHALLENGE_BYTES),
        .SIGNATURE_BYTES (SIGNATURE_BYTES)
    ) u_regfile (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_func    (s_func),
        .s_data    (s_data),
        .a_valid   (a_valid),
        .a_ready   (a_ready),
        .a_item    (a_item)
    );

    i2car_out_stage u_out_stage (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .a_valid     (a_valid),
        .a_ready     (a_ready),
        .a_item      (a_item),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_read_data (m_read_data),
        .m_past_end  (m_past_end)
    );

endmodule

### tb/i2c_auth_register_file_slave_checker.sv
// Checker for the I2C register file target: predicts every reply byte and compares it.
`timescale 1ns / 100ps

module i2c_auth_register_file_slave_checker
    import i2car_pkg::*;
#(
    parameter int CERT_BYTES      = 609,
    parameter int PAGE_BYTES      = 128,
    parameter int CHALLENGE_BYTES = 32,
    parameter int SIGNATURE_BYTES = 64
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  logic [1:0]            s_func,
    input  logic [7:0]            s_data,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  logic [7:0]            m_read_data,
    input  logic                  m_past_end,
    output int                    mismatch_count,
    output int                    pending_count
);

    typedef struct packed {
        logic [7:0] read_data;
        logic       past_end;
    } bus_reply_t;

    bus_reply_t expected_replies[$];

    // Configuration as the block should hold it.
    logic [31:0] dev_id;
    logic [7:0]  major_ver;
    logic [47:0] serial_id;

    // Register file state as the block should hold it.
    logic [7:0]  sel_reg;
    logic        want_addr;
    logic [7:0]  err_code;
    logic [7:0]  ctrl_status;
    logic [7:0]  chal_store [CHALLENGE_BYTES];
    logic [7:0]  chal_snap [CHALLENGE_BYTES];
    logic [15:0] chal_len;
    logic [5:0]  wr_pos;
    logic [9:0]  rd_pos;
    logic [9:0]  reply_len;
    logic [15:0] snap_word;

    function automatic void clear_model();
        dev_id      = DEVICE_ID_RESET;
        major_ver   = MAJOR_VERSION_RESET;
        serial_id   = ID_SERIAL_RESET;
        sel_reg     = '0;
        want_addr   = 1'b1;
        err_code    = '0;
        ctrl_status = '0;
        chal_len    = '0;
        wr_pos      = '0;
        rd_pos      = '0;
        reply_len   = '0;
        snap_word   = '0;
        for (int i = 0; i < CHALLENGE_BYTES; i++) begin
            chal_store[i] = '0;
            chal_snap[i]  = '0;
        end
    endfunction

    // Selecting a register rewinds the reply and freezes what it depends on.
    function automatic void select_reg(input logic [7:0] r);
        int off;
        sel_reg   = r;
        want_addr = 1'b0;
        wr_pos    = '0;
        if (r == REG_CHAL_LEN)
            chal_len = '0;
        rd_pos    = '0;
        snap_word = '0;
        for (int i = 0; i < CHALLENGE_BYTES; i++)
            chal_snap[i] = chal_store[i];
        reply_len = '0;
        if (r >= REG_CERT_FIRST && r <= REG_CERT_LAST) begin
            off = (int'(r) - int'(REG_CERT_FIRST)) * PAGE_BYTES;
            reply_len = (off < CERT_BYTES) ? 10'(CERT_BYTES - off) : '0;
        end else if (r <= REG_VERSION_LAST) begin
            reply_len = 10'(8 - int'(r));
        end else begin
            case (r)
                REG_ERROR: begin
                    snap_word = {8'h00, err_code};
                    reply_len = 10'd1;
                end
                REG_STATUS: begin
                    snap_word = {8'h00, ctrl_status};
                    reply_len = 10'd1;
                end
                REG_SIG_LEN:    reply_len = 10'd2;
                REG_SIGNATURE:  reply_len = 10'(SIGNATURE_BYTES);
                REG_CHAL_LEN: begin
                    snap_word = chal_len;
                    reply_len = 10'd2;
                end
                REG_CHALLENGE:  reply_len = 10'(CHALLENGE_BYTES);
                REG_CERT_LEN:   reply_len = 10'd2;
                REG_PROTO:      reply_len = 10'd1;
                REG_SERIAL_ROM: reply_len = 10'(SERIAL_ROM_LEN);
                REG_ID_SERIAL:  reply_len = 10'd7;
                default:        reply_len = '0;
            endcase
        end
    endfunction

    function automatic void store_write(input logic [7:0] d);
        case (sel_reg)
            REG_ERROR: err_code = d;
            REG_STATUS: begin
                ctrl_status = d;
                if (d[0]) begin
                    ctrl_status = STATUS_SIG_DONE;
                    err_code    = '0;
                end
            end
            REG_CHAL_LEN: begin
                if (wr_pos < 6'd2)
                    chal_len = {chal_len[7:0], d};
            end
            REG_CHALLENGE: begin
                if (int'(wr_pos) < CHALLENGE_BYTES)
                    chal_store[wr_pos] = d;
            end
            default: ;
        endcase
        if (wr_pos != 6'h3F)
            wr_pos = wr_pos + 6'd1;
    endfunction

    function automatic logic [7:0] reply_byte(input logic [9:0] pos);
        int p;
        int k;
        int idx;
        p = int'(pos);
        if (sel_reg >= REG_CERT_FIRST && sel_reg <= REG_CERT_LAST) begin
            idx = (int'(sel_reg) - int'(REG_CERT_FIRST)) * PAGE_BYTES + p;
            if (idx >= CERT_BYTES || idx >= CERT_ROM_LEN)
                return 8'h00;
            return CERT_ROM[idx];
        end
        if (sel_reg <= REG_VERSION_LAST) begin
            k = p + int'(sel_reg);
            if (k == 2)
                return major_ver;
            if (k >= 4 && k <= 7)
                return 8'(dev_id >> (8 * (7 - k)));
            return 8'h00;
        end
        case (sel_reg)
            REG_ERROR, REG_STATUS: return snap_word[7:0];
            REG_SIG_LEN:    return (p == 0) ? 8'(SIGNATURE_BYTES >> 8) : 8'(SIGNATURE_BYTES);
            REG_SIGNATURE:  return chal_snap[p % CHALLENGE_BYTES] ^ pos[7:0];
            REG_CHAL_LEN:   return (p == 0) ? snap_word[15:8] : snap_word[7:0];
            REG_CHALLENGE:  return chal_snap[p % CHALLENGE_BYTES];
            REG_CERT_LEN:   return (p == 0) ? 8'(CERT_BYTES >> 8) : 8'(CERT_BYTES);
            REG_PROTO:      return PROTO_BYTE;
            REG_SERIAL_ROM: return SERIAL_ROM[p % SERIAL_ROM_LEN];
            REG_ID_SERIAL: begin
                if (p == 0 || p > 6)
                    return 8'h00;
                return 8'(serial_id >> (8 * (6 - p)));
            end
            default: return 8'h00;
        endcase
    endfunction

    function automatic bus_reply_t predict_bus_event(input func_t f, input logic [7:0] d);
        bus_reply_t res;
        res = '0;
        case (f)
            FUNC_WRITE_START: begin
                want_addr = 1'b1;
                wr_pos    = '0;
            end
            FUNC_WRITE_BYTE: begin
                if (want_addr)
                    select_reg(d);
                else
                    store_write(d);
            end
            FUNC_READ_BYTE: begin
                if (rd_pos >= reply_len) begin
                    res.past_end = 1'b1;
                end else begin
                    res.read_data = reply_byte(rd_pos);
                    rd_pos = rd_pos + 10'd1;
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    always @(posedge aclk) begin : watch_channels
        bus_reply_t want;
        if (!aresetn) begin
            clear_model();
            expected_replies.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_addr)
                    CFG_DEVICE_ID:     dev_id    = cfg_wdata[31:0];
                    CFG_MAJOR_VERSION: major_ver = cfg_wdata[7:0];
                    CFG_ID_SERIAL:     serial_id = cfg_wdata[47:0];
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                if (expected_replies.size() == 0) begin
                    $error("unexpected result transfer: read_data %h past_end %b",
                           m_read_data, m_past_end);
                    mismatch_count++;
                end else begin
                    want = expected_replies.pop_front();
                    if (m_read_data !== want.read_data) begin
                        $error("read_data: expected %h, actual %h", want.read_data, m_read_data);
                        mismatch_count++;
                    end
                    if (m_past_end !== want.past_end) begin
                        $error("past_end: expected %b, actual %b", want.past_end, m_past_end);
                        mismatch_count++;
                    end
                end
            end
            if (s_valid && s_ready)
                expected_replies.push_back(predict_bus_event(func_t'(s_func), s_data));
        end
        pending_count = expected_replies.size();
    end

endmodule

### tb/i2c_auth_register_file_slave_tb.sv
// Testbench top for the I2C register file target: bus event stimulus, config phases, verdict.
`timescale 1ns / 100ps

module i2c_auth_register_file_slave_tb;
    import i2car_pkg::*;

    localparam int CERT_BYTES      = 609;
    localparam int PAGE_BYTES      = 128;
    localparam int CHALLENGE_BYTES = 32;
    localparam int SIGNATURE_BYTES = 64;
    localparam int PHASES          = 4;
    localparam int ITEM_TARGET     = 1750;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_valid;
    logic                  s_ready;
    logic [1:0]            s_func;
    logic [7:0]            s_data;
    logic                  m_valid;
    logic                  m_ready;
    logic [7:0]            m_read_data;
    logic                  m_past_end;
    int                    mismatch_count;
    int                    pending_count;

    int burst_left;
    int events_sent;

    i2c_auth_register_file_slave #(
        .CERT_BYTES(CERT_BYTES),
        .PAGE_BYTES(PAGE_BYTES),
        .CHALLENGE_BYTES(CHALLENGE_BYTES),
        .SIGNATURE_BYTES(SIGNATURE_BYTES)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en),
        .cfg_addr(cfg_addr),
        .cfg_wdata(cfg_wdata),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_func(s_func),
        .s_data(s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_read_data(m_read_data),
        .m_past_end(m_past_end)
    );

    i2c_auth_register_file_slave_checker #(
        .CERT_BYTES(CERT_BYTES),
        .PAGE_BYTES(PAGE_BYTES),
        .CHALLENGE_BYTES(CHALLENGE_BYTES),
        .SIGNATURE_BYTES(SIGNATURE_BYTES)
    ) u_checker (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en),
        .cfg_addr(cfg_addr),
        .cfg_wdata(cfg_wdata),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_func(s_func),
        .s_data(s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_read_data(m_read_data),
        .m_past_end(m_past_end),
        .mismatch_count(mismatch_count),
        .pending_count(pending_count)
    );

    initial aclk = 1'b0;
    always #2 aclk = ~aclk;

    initial begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // Receiver: free-running stretches, random stalls, periodic stalls and long hold-offs.
    initial begin : receiver
        int mode;
        int span;
        int period;
        m_ready = 1'b0;
        forever begin
            mode   = $urandom_range(0, 9);
            span   = $urandom_range(20, 60);
            period = $urandom_range(2, 5);
            if (mode == 0)
                span = $urandom_range(40, 80);
            for (int i = 0; i < span; i++) begin
                @(negedge aclk);
                if (mode == 0)
                    m_ready <= 1'b0;
                else if (mode <= 3)
                    m_ready <= 1'b1;
                else if (mode <= 6)
                    m_ready <= 1'($urandom_range(0, 1));
                else
                    m_ready <= (i % period) != 0;
            end
        end
    end

    // Reply length per register, used only to aim reads at the end of a reply.
    function automatic int reply_span(input logic [7:0] r);
        int off;
        if (r >= REG_CERT_FIRST && r <= REG_CERT_LAST) begin
            off = (int'(r) - int'(REG_CERT_FIRST)) * PAGE_BYTES;
            return (off < CERT_BYTES) ? CERT_BYTES - off : 0;
        end
        if (r <= REG_VERSION_LAST)
            return 8 - int'(r);
        case (r)
            REG_ERROR, REG_STATUS, REG_PROTO:        return 1;
            REG_SIG_LEN, REG_CHAL_LEN, REG_CERT_LEN: return 2;
            REG_SIGNATURE:                           return SIGNATURE_BYTES;
            REG_CHALLENGE:                           return CHALLENGE_BYTES;
            REG_SERIAL_ROM:                          return SERIAL_ROM_LEN;
            REG_ID_SERIAL:                           return 7;
            default:                                 return 0;
        endcase
    endfunction

    function automatic logic [7:0] pick_register(input bit writable);
        int roll;
        if (writable) begin
            case ($urandom_range(0, 3))
                0:       return REG_ERROR;
                1:       return REG_STATUS;
                2:       return REG_CHAL_LEN;
                default: return REG_CHALLENGE;
            endcase
        end
        roll = $urandom_range(0, 99);
        if (roll < 12)
            return 8'($urandom_range(0, 255));
        if (roll < 24)
            return REG_VERSION_LAST - 8'($urandom_range(0, 4));
        if (roll < 36)
            return REG_CERT_FIRST + 8'($urandom_range(0, 9));
        case ($urandom_range(0, 11))
            0:       return REG_ERROR;
            1:       return REG_STATUS;
            2:       return REG_SIG_LEN;
            3:       return REG_SIGNATURE;
            4:       return REG_CHAL_LEN;
            5:       return REG_CHALLENGE;
            6:       return REG_CERT_LEN;
            7:       return REG_PROTO;
            8:       return REG_SERIAL_ROM;
            9:       return REG_ID_SERIAL;
            10:      return REG_SIGNATURE;
            default: return REG_CHALLENGE;
        endcase
    endfunction

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_event(input func_t f, input logic [7:0] d);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            burst_left = $urandom_range(1, 30);
        end
        burst_left--;
        s_valid <= 1'b1;
        s_func  <= f;
        s_data  <= d;
        do @(posedge aclk); while (!s_ready);
        if (f != FUNC_OTHER)
            events_sent++;
        @(negedge aclk);
    endtask

    task automatic drain_replies();
        s_valid <= 1'b0;
        burst_left = 0;
        do @(negedge aclk); while (pending_count != 0);
    endtask

    task automatic send_reads(input logic [7:0] r);
        int span;
        int n;
        span = reply_span(r);
        if (span > SIGNATURE_BYTES && $urandom_range(0, 15) != 0)
            n = $urandom_range(1, 24);
        else if ($urandom_range(0, 2) == 0)
            n = span + $urandom_range(0, 3);
        else
            n = $urandom_range(0, span + 1);
        repeat (n) send_event(FUNC_READ_BYTE, 8'($urandom_range(0, 255)));
    endtask

    // One write transfer with its register byte and data, then reads, usually after a new selection.
    task automatic run_session();
        logic [7:0] r;
        int         n;
        r = pick_register($urandom_range(0, 1));
        send_event(FUNC_WRITE_START, 8'($urandom_range(0, 255)));
        send_event(FUNC_WRITE_BYTE, r);
        if (r == REG_CHALLENGE)
            n = ($urandom_range(0, 5) == 0) ? $urandom_range(33, 70) : $urandom_range(1, 32);
        else if (r == REG_CHAL_LEN)
            n = $urandom_range(0, 4);
        else
            n = $urandom_range(0, 3);
        repeat (n) send_event(FUNC_WRITE_BYTE, 8'($urandom_range(0, 255)));
        if ($urandom_range(0, 3) != 0) begin
            if (r == REG_CHALLENGE && $urandom_range(0, 1) == 1)
                r = ($urandom_range(0, 1) == 1) ? REG_SIGNATURE : REG_CHALLENGE;
            else if ($urandom_range(0, 2) != 0)
                r = pick_register(0);
            send_event(FUNC_WRITE_START, 8'($urandom_range(0, 255)));
            send_event(FUNC_WRITE_BYTE, r);
        end
        send_reads(r);
    endtask

    task automatic write_config(input int phase);
        logic [31:0] id_val;
        logic [7:0]  ver_val;
        logic [47:0] serial_val;
        case (phase)
            0: begin
                id_val     = '0;
                ver_val    = '0;
                serial_val = '0;
            end
            1: begin
                id_val     = '1;
                ver_val    = '1;
                serial_val = '1;
            end
            default: begin
                id_val     = $urandom;
                ver_val    = 8'($urandom);
                serial_val = {16'($urandom), 32'($urandom)};
            end
        endcase
        cfg_wr_en <= 1'b1;
        cfg_addr  <= CFG_DEVICE_ID;
        cfg_wdata <= {16'h0000, id_val};
        @(negedge aclk);
        cfg_addr  <= CFG_MAJOR_VERSION;
        cfg_wdata <= {40'h0, ver_val};
        @(negedge aclk);
        cfg_addr  <= CFG_ID_SERIAL;
        cfg_wdata <= serial_val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
    endtask

    initial begin : stimulus
        int roll;
        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_addr    = '0;
        cfg_wdata   = '0;
        s_valid     = 1'b0;
        s_func      = FUNC_OTHER;
        s_data      = '0;
        burst_left  = 0;
        events_sent = 0;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: read before any selection, other events, error and control
        // writes, error snapshot, version block end, unknown register and the
        // cleared challenge length.
        send_event(FUNC_READ_BYTE, 8'h00);
        send_event(FUNC_OTHER, 8'hFF);
        send_event(FUNC_WRITE_START, 8'h00);
        send_event(FUNC_WRITE_BYTE, REG_ERROR);
        send_event(FUNC_WRITE_BYTE, 8'hFF);
        send_event(FUNC_WRITE_START, 8'hFF);
        send_event(FUNC_WRITE_BYTE, REG_STATUS);
        send_event(FUNC_WRITE_BYTE, 8'h01);
        send_event(FUNC_WRITE_START, 8'h00);
        send_event(FUNC_WRITE_BYTE, REG_ERROR);
        send_event(FUNC_READ_BYTE, 8'h00);
        send_event(FUNC_READ_BYTE, 8'hFF);
        send_event(FUNC_WRITE_START, 8'h00);
        send_event(FUNC_WRITE_BYTE, REG_VERSION_LAST);
        repeat (5) send_event(FUNC_READ_BYTE, 8'h00);
        send_event(FUNC_WRITE_START, 8'h00);
        send_event(FUNC_WRITE_BYTE, 8'hFF);
        send_event(FUNC_READ_BYTE, 8'h00);
        send_event(FUNC_WRITE_START, 8'h00);
        send_event(FUNC_WRITE_BYTE, REG_CHAL_LEN);
        send_event(FUNC_READ_BYTE, 8'h00);

        for (int phase = 0; phase < PHASES; phase++) begin
            drain_replies();
            repeat (4) @(negedge aclk);
            write_config(phase);
            while (events_sent < (phase + 1) * ITEM_TARGET / PHASES) begin
                roll = $urandom_range(0, 99);
                if (roll < 10) begin
                    repeat ($urandom_range(1, 4))
                        send_event(func_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
                end else if (roll < 14) begin
                    // Writes or reads with random bytes, sometimes after a write start.
                    if ($urandom_range(0, 1) == 1)
                        send_event(FUNC_WRITE_START, 8'($urandom_range(0, 255)));
                    repeat ($urandom_range(1, 3))
                        send_event($urandom_range(0, 1) ? FUNC_READ_BYTE : FUNC_WRITE_BYTE,
                                   8'($urandom_range(0, 255)));
                end else if (roll < 16) begin
                    drain_replies();
                end else begin
                    run_session();
                end
            end
        end

        drain_replies();
        repeat (10) @(negedge aclk);
        if (mismatch_count == 0 && pending_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
